/* sv/gbc_pkg.sv */
// Shared types, constants and register codes of the bilinear colormap upscaler.
`default_nettype none

package gbc_pkg;

    // Default block size in pixels.
    localparam int SCALE_X_DEF = 4;
    localparam int SCALE_Y_DEF = 4;

    // Q16.16 unit.
    localparam int ONE_Q = 65536;

    // Division lanes: each divider needs ten steps plus a load and a hand-off.
    localparam int DIV_STEPS = 10;
    localparam int STEP_W    = 4;
    localparam int NUM_LANES = 12;
    localparam int LANE_W    = $clog2(NUM_LANES);

    // Datapath widths, sized for the largest block of 8 by 8 pixels.
    localparam int PROD_W = 40;
    localparam int N_W    = 40;
    localparam int X_W    = 41;
    localparam int A_W    = 48;
    localparam int B_W    = 40;
    localparam int REM_W  = A_W - 1;
    localparam int DEN_W  = B_W - 1 + DIV_STEPS - 1;
    localparam int Q_W    = DIV_STEPS;
    localparam int R_W    = 12;

    // Palette indices.
    localparam logic [7:0] COLOR_BASE        = 8'd30;
    localparam logic [7:0] COLOR_MID         = 8'd135;
    localparam logic [7:0] COLOR_WHITE       = 8'd254;
    localparam logic [7:0] COLOR_OXIDE       = 8'd5;
    localparam logic [7:0] COLOR_NITRIDE     = 8'd250;
    localparam logic [7:0] COLOR_WHITE_ALT   = 8'd0;
    localparam logic [7:0] COLOR_OXIDE_ALT   = 8'd255;
    localparam logic [7:0] COLOR_SAT_HIGH    = 8'd255;

    typedef enum logic [2:0] {
        CFG_MARKER  = 3'd0,
        CFG_LOW     = 3'd1,
        CFG_HIGH    = 3'd2,
        CFG_CLIP    = 3'd3,
        CFG_PALETTE = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LANE_IDLE,
        LANE_DIV,
        LANE_DONE
    } lane_state_t;

    typedef struct packed {
        logic signed [31:0] corner_top_left;
        logic signed [31:0] corner_top_right;
        logic signed [31:0] corner_bottom_right;
        logic signed [31:0] corner_bottom_left;
    } item_t;

    typedef struct packed {
        logic [2:0] sub_col;
        logic [2:0] sub_row;
        logic [7:0] color_index;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] marker;
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic               clip;
        logic               alt;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic                  base30;
        logic                  fixed;
        logic [7:0]            fixed_color;
        logic [2:0]            col;
        logic [2:0]            row;
        logic                  last;
    } job_t;

    typedef struct packed {
        logic   valid;
        pixel_t px;
    } lane_res_t;

endpackage

`default_nettype wire

/* sv/gbc_lane.sv */
// One division lane: restoring divider that turns a scaled numerator into a colour index.
`default_nettype none

module gbc_lane (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire gbc_pkg::job_t     job,
    input  wire logic              take,
    output logic                   free,
    output gbc_pkg::lane_res_t     res
);

    gbc_pkg::lane_state_t state_reg, state_next;

    logic [gbc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [gbc_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [gbc_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [gbc_pkg::Q_W-1:0]    q_reg, q_next;
    logic                       neg_reg, base30_reg, fixed_reg;
    logic [7:0]                 fcolor_reg;
    logic [2:0]                 col_reg, row_reg;
    logic                       last_reg;

    logic [gbc_pkg::A_W-1:0]    a_mag;
    logic [gbc_pkg::B_W-1:0]    b_mag;
    logic                       ge;
    logic signed [gbc_pkg::R_W-1:0] q_signed, r_val;
    logic [7:0]                 color;

    assign a_mag = job.a[gbc_pkg::A_W-1] ? gbc_pkg::A_W'(-job.a) : gbc_pkg::A_W'(job.a);
    assign b_mag = job.b[gbc_pkg::B_W-1] ? gbc_pkg::B_W'(-job.b) : gbc_pkg::B_W'(job.b);
    assign ge    = gbc_pkg::DEN_W'(rem_reg) >= den_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbc_pkg::LANE_IDLE:
            begin
                if (load)
                begin
                    state_next = job.fixed ? gbc_pkg::LANE_DONE : gbc_pkg::LANE_DIV;
                end
            end
            gbc_pkg::LANE_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = gbc_pkg::LANE_DONE;
                end
            end
            gbc_pkg::LANE_DONE:
            begin
                if (take)
                begin
                    state_next = gbc_pkg::LANE_IDLE;
                end
            end
            default:
            begin
                state_next = gbc_pkg::LANE_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        free      = 1'b0;
        case (state_reg)
            gbc_pkg::LANE_IDLE:
            begin
                free = 1'b1;
                if (load)
                begin
                    step_next = gbc_pkg::STEP_W'(gbc_pkg::DIV_STEPS - 1);
                    rem_next  = gbc_pkg::REM_W'(a_mag);
                    den_next  = {b_mag[gbc_pkg::B_W-2:0], {(gbc_pkg::DIV_STEPS-1){1'b0}}};
                    q_next    = '0;
                end
            end
            gbc_pkg::LANE_DIV:
            begin
                step_next = step_reg - 1'b1;
                if (ge)
                begin
                    rem_next = rem_reg - den_reg[gbc_pkg::REM_W-1:0];
                end
                q_next   = {q_reg[gbc_pkg::Q_W-2:0], ge};
                den_next = den_reg >> 1;
            end
            default:
            begin
                free = 1'b0;
            end
        endcase
    end

    // A quotient too large for ten bits leaves all ones, which saturates either way.
    always_comb
    begin
        q_signed = neg_reg ? -$signed(gbc_pkg::R_W'(q_reg)) : $signed(gbc_pkg::R_W'(q_reg));
        r_val    = q_signed + (base30_reg ? $signed(gbc_pkg::R_W'(gbc_pkg::COLOR_BASE))
                                          : $signed(gbc_pkg::R_W'(0)));
        if (fixed_reg)
        begin
            color = fcolor_reg;
        end
        else if (r_val < 0)
        begin
            color = 8'd0;
        end
        else if (r_val > $signed(gbc_pkg::R_W'(255)))
        begin
            color = gbc_pkg::COLOR_SAT_HIGH;
        end
        else
        begin
            color = r_val[7:0];
        end
    end

    assign res.valid          = (state_reg == gbc_pkg::LANE_DONE);
    assign res.px.sub_col     = col_reg;
    assign res.px.sub_row     = row_reg;
    assign res.px.color_index = color;
    assign res.px.last_pixel  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbc_pkg::LANE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        if (load && state_reg == gbc_pkg::LANE_IDLE)
        begin
            neg_reg    <= (job.a[gbc_pkg::A_W-1] ^ job.b[gbc_pkg::B_W-1]);
            base30_reg <= job.base30;
            fixed_reg  <= job.fixed;
            fcolor_reg <= job.fixed_color;
            col_reg    <= job.col;
            row_reg    <= job.row;
            last_reg   <= job.last;
        end
    end

endmodule

`default_nettype wire

/* sv/gbc_front.sv */
// Pixel sequencer and interpolation pipeline that prepares one division job per pixel.
`default_nettype none

module gbc_front #(
    parameter int SCALE_X = gbc_pkg::SCALE_X_DEF,
    parameter int SCALE_Y = gbc_pkg::SCALE_Y_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gbc_pkg::cfg_t                 cfg,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire gbc_pkg::item_t                item,
    input  wire logic [gbc_pkg::NUM_LANES-1:0] lane_free,
    output gbc_pkg::job_t                      job,
    output logic [gbc_pkg::LANE_W-1:0]         job_lane
);

    localparam int S = SCALE_X * SCALE_Y;
    localparam logic signed [7:0]  S_C   = 8'(S);
    localparam logic signed [15:0] S30_C = 16'(S * 30);
    localparam logic signed [gbc_pkg::X_W-1:0] CLIP_S = gbc_pkg::X_W'(14 * gbc_pkg::ONE_Q * S);
    localparam logic signed [gbc_pkg::X_W-1:0] C28_S  = gbc_pkg::X_W'(28 * gbc_pkg::ONE_Q * S);
    localparam logic signed [33:0] C28 = 34'(28 * gbc_pkg::ONE_Q);
    localparam logic signed [gbc_pkg::A_W-1:0] SPAN = gbc_pkg::A_W'(210);

    // Config-derived scaling terms, two register levels.
    logic signed [32:0]             d_reg;
    logic signed [33:0]             e_reg;
    logic signed [gbc_pkg::N_W-1:0] lows_reg, highs_reg;
    logic                           dz_reg, ez_reg;
    logic signed [gbc_pkg::B_W-1:0] sd_reg, se_reg;
    logic signed [gbc_pkg::A_W-1:0] sd30_reg;
    logic signed [32:0]             d_next;
    logic signed [33:0]             e_next;

    // Sequencer.
    logic        busy_reg, busy_next;
    logic [2:0]  col_reg, col_next, row_reg, row_next;
    logic        gen_last, adv, emit, accept, dispatch;
    logic signed [31:0] h_tl_reg, h_tr_reg, h_br_reg, h_bl_reg;
    logic        flat_reg, flat_next;
    logic [7:0]  fcol_reg, fcol_next;
    logic signed [33:0] v1x, mk;

    logic [3:0] ci, cj;
    logic [6:0] w_tl, w_tr, w_br, w_bl;

    // Stage 1: products.
    logic p1_valid_reg;
    logic signed [gbc_pkg::PROD_W-1:0] p_tl_reg, p_tr_reg, p_br_reg, p_bl_reg;
    logic [2:0] p1_col_reg, p1_row_reg;
    logic       p1_last_reg, p1_flat_reg;
    logic [7:0] p1_fcol_reg;

    // Stage 2: sum.
    logic p2_valid_reg;
    logic signed [gbc_pkg::N_W-1:0] n_reg, n_next;
    logic [2:0] p2_col_reg, p2_row_reg;
    logic       p2_last_reg, p2_flat_reg;
    logic [7:0] p2_fcol_reg;

    // Stage 3: offset numerator and special colours.
    logic p3_valid_reg;
    logic signed [gbc_pkg::X_W-1:0] x_reg, x_next, n_ext;
    logic       fixed_reg, fixed_next, in_band;
    logic [7:0] fc_reg, fc_next;
    logic [2:0] p3_col_reg, p3_row_reg;
    logic       p3_last_reg;

    // Stage 4: job register.
    gbc_pkg::job_t job_reg, job_next;
    logic [gbc_pkg::LANE_W-1:0] wr_reg, wr_next;

    always_comb
    begin
        d_next = $signed({cfg.high[31], cfg.high}) - $signed({cfg.low[31], cfg.low});
        e_next = 34'(d_next) - C28;
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        e_reg     <= e_next;
        lows_reg  <= cfg.low * S_C;
        highs_reg <= cfg.high * S_C;
        dz_reg    <= (d_next == '0);
        ez_reg    <= (e_next == '0);
        sd_reg    <= gbc_pkg::B_W'(d_reg) * S_C;
        se_reg    <= gbc_pkg::B_W'(e_reg) * S_C;
        sd30_reg  <= gbc_pkg::A_W'(d_reg) * S30_C;
    end

    // Handshake and sequencing.
    assign dispatch   = job_reg.valid && lane_free[wr_reg];
    assign adv        = !job_reg.valid || lane_free[wr_reg];
    assign gen_last   = (col_reg == 3'(SCALE_X - 1)) && (row_reg == 3'(SCALE_Y - 1));
    assign emit       = busy_reg && adv;
    assign item_stall = busy_reg && !(adv && gen_last);
    assign accept     = item_valid && !item_stall;

    // Marker tests without wrap.
    assign v1x = 34'(item.corner_top_left);
    assign mk  = 34'(cfg.marker);

    always_comb
    begin
        flat_next = 1'b1;
        if (v1x == mk - 34'sd65536)
        begin
            fcol_next = cfg.alt ? gbc_pkg::COLOR_OXIDE_ALT : gbc_pkg::COLOR_OXIDE;
        end
        else if (v1x == mk - 34'sd131072)
        begin
            fcol_next = gbc_pkg::COLOR_NITRIDE;
        end
        else if (v1x == mk)
        begin
            fcol_next = cfg.alt ? gbc_pkg::COLOR_WHITE_ALT : gbc_pkg::COLOR_WHITE;
        end
        else
        begin
            flat_next = 1'b0;
            fcol_next = gbc_pkg::COLOR_BASE;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (emit)
        begin
            if (gen_last)
            begin
                busy_next = 1'b0;
                col_next  = '0;
                row_next  = '0;
            end
            else if (col_reg == 3'(SCALE_X - 1))
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    assign ci   = 4'(SCALE_X) - {1'b0, col_reg};
    assign cj   = 4'(SCALE_Y) - {1'b0, row_reg};
    assign w_tl = 7'(ci) * 7'(cj);
    assign w_tr = 7'(col_reg) * 7'(cj);
    assign w_br = 7'(col_reg) * 7'(row_reg);
    assign w_bl = 7'(ci) * 7'(row_reg);

    assign n_next = p_tl_reg + p_tr_reg + p_br_reg + p_bl_reg;

    // Stage 3: linear or clipped numerator; flat, mid-band and zero-span pixels bypass division.
    always_comb
    begin
        n_ext   = gbc_pkg::X_W'(n_reg);
        in_band = (n_ext > -CLIP_S) && (n_ext < CLIP_S);
        fixed_next = 1'b1;
        fc_next    = gbc_pkg::COLOR_BASE;
        if (cfg.clip)
        begin
            x_next = gbc_pkg::X_W'(highs_reg) - n_ext - (n_reg[gbc_pkg::N_W-1] ? C28_S : '0);
            if (p2_flat_reg)
            begin
                fc_next = p2_fcol_reg;
            end
            else if (in_band)
            begin
                fc_next = gbc_pkg::COLOR_MID;
            end
            else if (!ez_reg)
            begin
                fixed_next = 1'b0;
            end
        end
        else
        begin
            x_next = n_ext - gbc_pkg::X_W'(lows_reg);
            if (p2_flat_reg)
            begin
                fc_next = p2_fcol_reg;
            end
            else if (!dz_reg)
            begin
                fixed_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        job_next             = job_reg;
        job_next.valid       = p3_valid_reg;
        job_next.a           = gbc_pkg::A_W'(x_reg) * SPAN + (cfg.clip ? '0 : sd30_reg);
        job_next.b           = cfg.clip ? se_reg : sd_reg;
        job_next.base30      = cfg.clip;
        job_next.fixed       = fixed_reg;
        job_next.fixed_color = fc_reg;
        job_next.col         = p3_col_reg;
        job_next.row         = p3_row_reg;
        job_next.last        = p3_last_reg;
    end

    always_comb
    begin
        wr_next = wr_reg;
        if (dispatch)
        begin
            wr_next = (wr_reg == gbc_pkg::LANE_W'(gbc_pkg::NUM_LANES - 1)) ? '0 : wr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            job_reg      <= '0;
            wr_reg       <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            wr_reg   <= wr_next;
            if (adv)
            begin
                p1_valid_reg <= busy_reg;
                p2_valid_reg <= p1_valid_reg;
                p3_valid_reg <= p2_valid_reg;
                job_reg      <= job_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_tl_reg <= item.corner_top_left;
            h_tr_reg <= item.corner_top_right;
            h_br_reg <= item.corner_bottom_right;
            h_bl_reg <= item.corner_bottom_left;
            flat_reg <= flat_next;
            fcol_reg <= fcol_next;
        end
        if (adv)
        begin
            p_tl_reg    <= h_tl_reg * $signed({1'b0, w_tl});
            p_tr_reg    <= h_tr_reg * $signed({1'b0, w_tr});
            p_br_reg    <= h_br_reg * $signed({1'b0, w_br});
            p_bl_reg    <= h_bl_reg * $signed({1'b0, w_bl});
            p1_col_reg  <= col_reg;
            p1_row_reg  <= row_reg;
            p1_last_reg <= gen_last;
            p1_flat_reg <= flat_reg;
            p1_fcol_reg <= fcol_reg;

            n_reg       <= n_next;
            p2_col_reg  <= p1_col_reg;
            p2_row_reg  <= p1_row_reg;
            p2_last_reg <= p1_last_reg;
            p2_flat_reg <= p1_flat_reg;
            p2_fcol_reg <= p1_fcol_reg;

            x_reg       <= x_next;
            fixed_reg   <= fixed_next;
            fc_reg      <= fc_next;
            p3_col_reg  <= p2_col_reg;
            p3_row_reg  <= p2_row_reg;
            p3_last_reg <= p2_last_reg;
        end
    end

    assign job      = job_reg;
    assign job_lane = wr_reg;

endmodule

`default_nettype wire

/* sv/gbc_merge.sv */
// Merging stage: collects lane results in issue order into the output register.
`default_nettype none

module gbc_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gbc_pkg::lane_res_t            res [gbc_pkg::NUM_LANES],
    output logic [gbc_pkg::NUM_LANES-1:0]      take,
    output logic                               pixel_valid,
    input  wire logic                          pixel_stall,
    output gbc_pkg::pixel_t                    pixel
);

    logic [gbc_pkg::LANE_W-1:0] rd_reg, rd_next;
    logic                       out_valid_reg, out_valid_next;
    gbc_pkg::pixel_t            out_reg;
    logic                       grab;

    assign grab = res[rd_reg].valid && (!out_valid_reg || !pixel_stall);

    always_comb
    begin
        take = '0;
        take[rd_reg] = grab;
        rd_next = rd_reg;
        if (grab)
        begin
            rd_next = (rd_reg == gbc_pkg::LANE_W'(gbc_pkg::NUM_LANES - 1)) ? '0 : rd_reg + 1'b1;
        end
        out_valid_next = grab || (out_valid_reg && pixel_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grab)
        begin
            out_reg <= res[rd_reg].px;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

endmodule

`default_nettype wire

/* sv/grid_bilinear_colormap.sv */
// Top level of the bilinear grid upscaler with colormap.
`default_nettype none

// Each accepted item holds the four Q16.16 corner values of one grid element and yields
// SCALE_X*SCALE_Y pixel transfers, row by row with the column running fastest; the last
// one carries last_pixel. The block sustains one pixel per clock while the receiver does
// not stall, and the next element is taken while the current one still drains. That
// rate is set by the pixel sequencer, which issues one pixel a cycle into an
// interpolation pipeline while that pipeline can advance; a pixel not bypassed needs a
// ten-step restoring division for its colour scaling, and twelve division lanes take
// pixels in turn so that a lane is free again by the time its next pixel arrives. The
// merging stage reads the lanes in the same order, so the pixel order is kept.
// Configuration writes are always taken (cfg_ready is tied high) and must only be made
// while the block holds no element.
module grid_bilinear_colormap #(
    parameter int SCALE_X = gbc_pkg::SCALE_X_DEF,
    parameter int SCALE_Y = gbc_pkg::SCALE_Y_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire gbc_pkg::item_t  item,
    output logic                 pixel_valid,
    input  wire logic            pixel_stall,
    output gbc_pkg::pixel_t      pixel,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_data
);

    gbc_pkg::cfg_t cfg_reg, cfg_next;

    gbc_pkg::job_t                   job;
    logic [gbc_pkg::LANE_W-1:0]      job_lane;
    logic [gbc_pkg::NUM_LANES-1:0]   lane_free, lane_load, lane_take;
    gbc_pkg::lane_res_t              lane_res [gbc_pkg::NUM_LANES];

    // The configuration port never back-pressures.
    assign cfg_ready = 1'b1;

    // Register decode; an index beyond the list is a transfer that changes nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gbc_pkg::CFG_MARKER:  cfg_next.marker = cfg_data;
                gbc_pkg::CFG_LOW:     cfg_next.low    = cfg_data;
                gbc_pkg::CFG_HIGH:    cfg_next.high   = cfg_data;
                gbc_pkg::CFG_CLIP:    cfg_next.clip   = cfg_data[0];
                gbc_pkg::CFG_PALETTE: cfg_next.alt    = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.marker <= '0;
            cfg_reg.low    <= '0;
            cfg_reg.high   <= 32'sd65536;
            cfg_reg.clip   <= 1'b0;
            cfg_reg.alt    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gbc_front #(
        .SCALE_X (SCALE_X),
        .SCALE_Y (SCALE_Y)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .lane_free  (lane_free),
        .job        (job),
        .job_lane   (job_lane)
    );

    // Lanes are loaded in strict rotation, the same rotation the merger follows.
    for (genvar k = 0; k < gbc_pkg::NUM_LANES; k++)
    begin : g_lane
        assign lane_load[k] = job.valid && (job_lane == gbc_pkg::LANE_W'(k)) && lane_free[k];

        gbc_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (lane_load[k]),
            .job   (job),
            .take  (lane_take[k]),
            .free  (lane_free[k]),
            .res   (lane_res[k])
        );
    end

    gbc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (lane_res),
        .take        (lane_take),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

    // The final pixel of a block sits in its bottom-right corner.
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel.last_pixel |->
            pixel.sub_col == 3'(SCALE_X - 1) && pixel.sub_row == 3'(SCALE_Y - 1))
        else $error("last pixel flagged away from the block corner");

    // A pixel before the corner is never flagged as last.
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && (pixel.sub_col != 3'(SCALE_X - 1) || pixel.sub_row != 3'(SCALE_Y - 1))
            |-> !pixel.last_pixel)
        else $error("last pixel flagged inside the block");

    // The merger only collects from a lane that holds a finished result.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_take & lane_free) == '0)
        else $error("result taken from an idle lane");

    // At most one lane is loaded per cycle.
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(lane_load))
        else $error("several lanes loaded at once");

endmodule

`default_nettype wire

/* tb/grid_bilinear_colormap_tb.sv */
// Self-checking testbench of the bilinear grid upscaler with colormap.
`default_nettype none

module grid_bilinear_colormap_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SX = gbc_pkg::SCALE_X_DEF;
    localparam int SY = gbc_pkg::SCALE_Y_DEF;
    localparam longint Q = 65536;

    // Scoreboard: a software image of the block's settings, which turns every accepted
    // element into the queue of pixels that must come out, oldest first.
    class pixel_scoreboard;
        longint marker;
        longint low;
        longint high;
        bit clip;
        bit alt;
        gbc_pkg::pixel_t pending[$];
        int errors;
        int checked;

        function void set_reg(gbc_pkg::cfg_reg_t idx, logic [31:0] d);
            case (idx)
                gbc_pkg::CFG_MARKER:  marker = longint'(signed'(d));
                gbc_pkg::CFG_LOW:     low = longint'(signed'(d));
                gbc_pkg::CFG_HIGH:    high = longint'(signed'(d));
                gbc_pkg::CFG_CLIP:    clip = d[0];
                gbc_pkg::CFG_PALETTE: alt = d[0];
                default:     ;
            endcase
        endfunction

        function logic [7:0] clamp8(longint v);
            if (v < 0)
                return 8'd0;
            if (v > 255)
                return 8'd255;
            return v[7:0];
        endfunction

        // Colour of one pixel from its interpolated sum n, which is scaled by SX*SY.
        function logic [7:0] shade(longint n);
            longint s;
            longint d;
            longint num;
            s = SX * SY;
            if (!clip)
            begin
                d = high - low;
                if (d == 0)
                    return 8'd30;
                return clamp8((30 * s * d + (n - low * s) * 210) / (s * d));
            end
            if (n > -14 * Q * s && n < 14 * Q * s)
                return 8'd135;
            d = high - low - 28 * Q;
            if (d == 0)
                return 8'd30;
            num = high * s - n;
            if (n < 0)
                num = num - 28 * Q * s;
            return clamp8(30 + (num * 210) / (s * d));
        endfunction

        function void note_element(gbc_pkg::item_t it);
            longint c0;
            longint c1;
            longint c2;
            longint c3;
            longint n;
            bit flat;
            logic [7:0] fc;
            gbc_pkg::pixel_t p;
            c0 = it.corner_top_left;
            c1 = it.corner_top_right;
            c2 = it.corner_bottom_right;
            c3 = it.corner_bottom_left;
            flat = 1'b1;
            fc = 8'd0;
            if (c0 == marker - Q)
                fc = alt ? 8'd255 : 8'd5;
            else if (c0 == marker - 2 * Q)
                fc = 8'd250;
            else if (c0 == marker)
                fc = alt ? 8'd0 : 8'd254;
            else
                flat = 1'b0;
            for (int j = 0; j < SY; j++)
            begin
                for (int i = 0; i < SX; i++)
                begin
                    n = (SX - i) * (SY - j) * c0 + i * (SY - j) * c1 + i * j * c2
                        + (SX - i) * j * c3;
                    p.sub_col = i[2:0];
                    p.sub_row = j[2:0];
                    p.color_index = flat ? fc : shade(n);
                    p.last_pixel = (i == SX - 1 && j == SY - 1);
                    pending.push_back(p);
                end
            end
        endfunction

        function void check_pixel(gbc_pkg::pixel_t got);
            gbc_pkg::pixel_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report_error("pixel with no element outstanding", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.sub_col !== want.sub_col)
                report_error("sub_col", got, want);
            if (got.sub_row !== want.sub_row)
                report_error("sub_row", got, want);
            if (got.color_index !== want.color_index)
                report_error("color_index", got, want);
            if (got.last_pixel !== want.last_pixel)
                report_error("last_pixel", got, want);
        endfunction

        function void report_error(string what, gbc_pkg::pixel_t got, gbc_pkg::pixel_t want);
            errors++;
            if (errors <= 40)
                $display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    gbc_pkg::item_t item = '0;
    logic pixel_valid;
    logic pixel_stall = 1'b0;
    gbc_pkg::pixel_t pixel;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    pixel_scoreboard board;
    int elements_sent;
    int cfg_writes;
    bit hold_off;       // long receiver hold-off, driven by the stimulus process
    bit quiet;          // stretches where neither side idles

    always #2 clk = ~clk;

    grid_bilinear_colormap u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Every pixel transfer is checked at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            board.check_pixel(pixel);
    end

    // Receiver: draws a stall length per pixel, or holds off entirely when asked.
    initial
    begin : receiver
        int gap;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                pixel_stall <= 1'b1;
            else
            begin
                gap = quiet ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
                if (gap > 0)
                begin
                    pixel_stall <= 1'b1;
                    repeat (gap - 1) @(posedge clk);
                    @(posedge clk);
                end
                pixel_stall <= 1'b0;
                // Stay open until one pixel transfer has happened.
                do
                    @(posedge clk);
                while (!(pixel_valid && !pixel_stall) && !hold_off);
                pixel_stall <= 1'b0;
            end
        end
    end

    // One register write on the configuration channel, also mirrored in the scoreboard.
    task automatic write_reg(gbc_pkg::cfg_reg_t idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, d);
        cfg_writes++;
    endtask

    task automatic write_all(logic [31:0] m, logic [31:0] lo, logic [31:0] hi,
                             bit cl, bit al);
        write_reg(gbc_pkg::CFG_MARKER, m);
        write_reg(gbc_pkg::CFG_LOW, lo);
        write_reg(gbc_pkg::CFG_HIGH, hi);
        write_reg(gbc_pkg::CFG_CLIP, {31'd0, cl});
        write_reg(gbc_pkg::CFG_PALETTE, {31'd0, al});
        cfg_valid <= 1'b0;
    endtask

    // Offers one element after a random gap; the transfer completes when stall is low.
    // Valid stays high after the transfer so that a following element can come at once.
    task automatic send_element(gbc_pkg::item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        board.note_element(it);
        elements_sent++;
    endtask

    // Waits for every expected pixel, then lets the pipeline settle before a write.
    task automatic drain;
        item_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 40 * 65536) - 20 * 65536;
        endcase
    endfunction

    // Mostly ordinary elements; about one in five hits a marker.
    function automatic gbc_pkg::item_t rand_element();
        gbc_pkg::item_t it;
        it.corner_top_left = rand_value();
        it.corner_top_right = rand_value();
        it.corner_bottom_right = rand_value();
        it.corner_bottom_left = rand_value();
        if ($urandom_range(0, 4) == 0)
            it.corner_top_left = 32'(board.marker - $urandom_range(0, 2) * Q);
        return it;
    endfunction

    initial
    begin : stimulus
        logic [31:0] lo;
        logic [31:0] hi;
        board = new();
        board.marker = 0;
        board.low = 0;
        board.high = Q;
        board.clip = 0;
        board.alt = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed part under reset settings, then extreme settings.
        send_element('{32'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_element('{-32'sd65536, 32'sd0, 32'sd0, 32'sd0});
        send_element('{-32'sd131072, 32'sd0, 32'sd0, 32'sd0});
        send_element('{32'sd1, 32'sd65536, 32'sd32768, -32'sd5});
        send_element('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_element('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_element('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        drain();
        // Alternate palette, clipped mode, reversed range.
        write_all(32'd1000, 32'h0010_0000, 32'hFFF0_0000, 1'b1, 1'b1);
        send_element('{32'sd1000, 32'sd0, 32'sd0, 32'sd0});
        send_element('{32'sd1000 - 32'sd65536, 32'sd0, 32'sd0, 32'sd0});
        send_element('{32'sd1000 - 32'sd131072, 32'sd0, 32'sd0, 32'sd0});
        send_element('{32'sd917504, -32'sd917504, 32'sd917503, -32'sd917503});
        send_element('{32'h0100_0000, -32'sd16777216, 32'sd5, 32'sd0});
        drain();
        // Zero denominator in clipped mode, marker at the minimum.
        write_all(32'h8000_0000, 32'sd0, 32'sd1835008, 1'b1, 1'b0);
        send_element('{32'h8000_0000, 32'sd0, 32'sd0, 32'sd0});
        send_element('{32'h7FFF_0000, 32'sd3, 32'sd0, -32'sd3000000});
        drain();
        // Zero denominator in linear mode, then the widest range.
        write_all(32'h7FFF_FFFF, 32'sd77, 32'sd77, 1'b0, 1'b1);
        send_element('{32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0});
        send_element('{32'sd5, 32'sd100, 32'sd0, 32'sd1});
        drain();
        write_all(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_element('{32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 32'sd12345});
        send_element('{-32'sd65536, 32'sd0, 32'sd0, 32'sd0});
        drain();

        // Random phases, each with fresh settings. In one phase the receiver holds off
        // for a long stretch so the block backs up and stalls its input.
        for (int ph = 0; ph < 8; ph++)
        begin
            lo = rand_value();
            hi = ($urandom_range(0, 2) == 0) ? rand_value() : lo + $urandom_range(1, 80) * Q;
            write_all(rand_value(), lo, hi, $urandom_range(0, 1), $urandom_range(0, 1));
            quiet = (ph == 5);
            if (ph == 3)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 20; k++)
                send_element(rand_element());
            drain();
        end
        quiet = 1'b0;

        drain();
        $display("covered %0d elements and %0d pixels over %0d register writes",
                 elements_sent, board.checked, cfg_writes);
        $display("settings included clipped, linear, reversed and zero-width ranges");
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin : watchdog
        #4ms;
        $display("timeout with %0d pixels outstanding", board.pending.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
